// File: sv/bapr_pkg.sv
// ----------------------------------------------------------------------------
// bapr_pkg
// Shared codes and defaults for the bounding-box point register core.
// ----------------------------------------------------------------------------
package bapr_pkg;

  // Default coordinate width: unsigned Q16.8
  localparam int COORD_BITS_DEF = 24;

  // Depth of the job queue between front and back
  localparam int JOB_DEPTH_DEF = 2;

  // Multiplier digit width (bits of the extent taken per cycle)
  localparam int MUL_DIGIT = 16;

  typedef enum logic [1:0] {
    MODE_REF   = 2'd0,
    MODE_TGT   = 2'd1,
    MODE_XFORM = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

endpackage

// File: sv/bapr_fifo.sv
// ----------------------------------------------------------------------------
// bapr_fifo
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module bapr_fifo
  import bapr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = JOB_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/bapr_front.sv
// ----------------------------------------------------------------------------
// bapr_front
// Holds both boxes, takes requests and turns transform requests into jobs.
// ----------------------------------------------------------------------------
module bapr_front
  import bapr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [1:0]                mode,
  input  logic [COORD_BITS-1:0]     x_coord,
  input  logic [COORD_BITS-1:0]     y_coord,
  input  logic [COORD_BITS-1:0]     z_coord,
  output logic                      job_push,
  output logic [3*(4*COORD_BITS+2)-1:0] job_data
);

  localparam int CB = COORD_BITS;

  typedef struct packed {
    logic          degen;
    logic          below;
    logic [CB-1:0] rl;
    logic [CB-1:0] text;
    logic [CB-1:0] rext;
    logic [CB-1:0] diff;
  } axis_job_t;

  mode_t         mode_in;
  logic [CB-1:0] pt        [3];
  logic [CB-1:0] tgt_low   [3];
  logic [CB-1:0] tgt_high  [3];
  logic [CB-1:0] ref_low   [3];
  logic [CB-1:0] ref_high  [3];
  axis_job_t [2:0] job;

  assign mode_in  = mode_t'(mode);
  assign pt[0]    = x_coord;
  assign pt[1]    = y_coord;
  assign pt[2]    = z_coord;
  assign job_push = accept && (mode_in == MODE_XFORM);
  assign job_data = job;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      job[a].degen = (tgt_high[a] <= tgt_low[a]);
      job[a].below = (pt[a] < tgt_low[a]);
      job[a].rl    = ref_low[a];
      job[a].text  = tgt_high[a] - tgt_low[a];
      job[a].rext  = (ref_high[a] >= ref_low[a]) ? (ref_high[a] - ref_low[a]) : '0;
      job[a].diff  = job[a].below ? (tgt_low[a] - pt[a]) : (pt[a] - tgt_low[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        tgt_low[a]  <= '1;
        tgt_high[a] <= '0;
        ref_low[a]  <= '1;
        ref_high[a] <= '0;
      end
    end else if (accept) begin
      unique case (mode_in)
        MODE_CLEAR: begin
          for (int a = 0; a < 3; a++) begin
            tgt_low[a]  <= '1;
            tgt_high[a] <= '0;
            ref_low[a]  <= '1;
            ref_high[a] <= '0;
          end
        end
        MODE_REF: begin
          for (int a = 0; a < 3; a++) begin
            if (pt[a] < ref_low[a])  ref_low[a]  <= pt[a];
            if (pt[a] > ref_high[a]) ref_high[a] <= pt[a];
          end
        end
        MODE_TGT: begin
          for (int a = 0; a < 3; a++) begin
            if (pt[a] < tgt_low[a])  tgt_low[a]  <= pt[a];
            if (pt[a] > tgt_high[a]) tgt_high[a] <= pt[a];
          end
        end
        default: begin
          // transform requests leave the boxes alone
        end
      endcase
    end
  end

endmodule

// File: sv/bapr_lane.sv
// ----------------------------------------------------------------------------
// bapr_lane
// One axis: digit-serial multiply, radix-2 restoring divide, offset and clamp.
// ----------------------------------------------------------------------------
module bapr_lane
  import bapr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  degen,
  input  logic                  below,
  input  logic [COORD_BITS-1:0] rl,
  input  logic [COORD_BITS-1:0] text,
  input  logic [COORD_BITS-1:0] rext,
  input  logic [COORD_BITS-1:0] diff,
  output logic                  busy,
  output logic [COORD_BITS-1:0] res
);

  localparam int CB   = COORD_BITS;
  localparam int DIG  = MUL_DIGIT;
  localparam int NDIG = (CB + DIG - 1) / DIG;
  localparam int DW   = NDIG * DIG;
  localparam int AW   = CB + DW;
  localparam int NW   = $clog2(CB + 1);

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_CHK,
    L_DIV,
    L_FIN
  } lane_state_t;

  lane_state_t    state;
  logic           degen_r;
  logic           below_r;
  logic [CB-1:0]  rl_r;
  logic [CB-1:0]  text_r;
  logic [DW-1:0]  rext_sh;
  logic [CB-1:0]  diff_r;
  logic [AW-1:0]  acc;
  logic [CB-1:0]  rem;
  logic [CB-1:0]  dvd;
  logic [CB-1:0]  quo;
  logic [NW-1:0]  cnt;
  logic [CB+DIG-1:0] part;
  logic [CB:0]    trial;
  logic           fits;
  logic [CB:0]    sum;

  assign busy  = (state != L_IDLE);
  assign part  = (CB+DIG)'(diff_r) * (CB+DIG)'(rext_sh[DW-1 -: DIG]);
  assign trial = {rem, dvd[CB-1]};
  assign fits  = (trial >= {1'b0, text_r});
  assign sum   = {1'b0, quo} + {1'b0, rl_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            degen_r <= degen;
            below_r <= below;
            rl_r    <= rl;
            text_r  <= text;
            rext_sh <= DW'(rext);
            diff_r  <= diff;
            acc     <= '0;
            cnt     <= NW'(NDIG - 1);
            state   <= degen ? L_FIN : L_MUL;
          end
        end
        L_MUL: begin
          // take the extent top digit first
          acc     <= (acc << DIG) + AW'(part);
          rext_sh <= rext_sh << DIG;
          cnt     <= cnt - 1'b1;
          if (cnt == '0) state <= L_CHK;
        end
        L_CHK: begin
          // a high half not below the divisor means the quotient overflows
          if (acc[2*CB-1:CB] >= text_r) begin
            quo   <= '1;
            state <= L_FIN;
          end else begin
            rem   <= acc[2*CB-1:CB];
            dvd   <= acc[CB-1:0];
            quo   <= '0;
            cnt   <= NW'(CB - 1);
            state <= L_DIV;
          end
        end
        L_DIV: begin
          rem <= fits ? CB'(trial - {1'b0, text_r}) : trial[CB-1:0];
          quo <= {quo[CB-2:0], fits};
          dvd <= dvd << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= L_FIN;
        end
        L_FIN: begin
          if (degen_r) begin
            res <= rl_r;
          end else if (below_r) begin
            res <= (quo >= rl_r) ? '0 : (rl_r - quo);
          end else begin
            res <= sum[CB] ? '1 : sum[CB-1:0];
          end
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// File: sv/bapr_back.sv
// ----------------------------------------------------------------------------
// bapr_back
// Pulls jobs from the queue, runs the three axis lanes, holds the result.
// ----------------------------------------------------------------------------
module bapr_back
  import bapr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_empty,
  input  logic [3*(4*COORD_BITS+2)-1:0] job_data,
  output logic                          job_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [COORD_BITS-1:0]         x_mapped,
  output logic [COORD_BITS-1:0]         y_mapped,
  output logic [COORD_BITS-1:0]         z_mapped,
  output logic [2:0]                    degenerate_axes
);

  localparam int CB = COORD_BITS;

  typedef struct packed {
    logic          degen;
    logic          below;
    logic [CB-1:0] rl;
    logic [CB-1:0] text;
    logic [CB-1:0] rext;
    logic [CB-1:0] diff;
  } axis_job_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  back_state_t     state;
  axis_job_t [2:0] job;
  logic [2:0]      lane_busy;
  logic [CB-1:0]   lane_res [3];
  logic [2:0]      degen_r;
  logic            out_valid;
  logic            out_free;
  logic            out_load;

  assign job      = job_data;
  assign job_pop  = (state == B_IDLE) && !job_empty;
  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign out_load = (state == B_RUN) && (lane_busy == '0) && out_free;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    bapr_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (job_pop),
      .degen (job[a].degen),
      .below (job[a].below),
      .rl    (job[a].rl),
      .text  (job[a].text),
      .rext  (job[a].rext),
      .diff  (job[a].diff),
      .busy  (lane_busy[a]),
      .res   (lane_res[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_pop) begin
            degen_r <= {job[2].degen, job[1].degen, job[0].degen};
            state   <= B_RUN;
          end
        end
        B_RUN: begin
          // hold the lane results until the output register frees up
          if (out_load) begin
            x_mapped        <= lane_res[0];
            y_mapped        <= lane_res[1];
            z_mapped        <= lane_res[2];
            degenerate_axes <= degen_r;
            state           <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: sv/bbox_affine_point_register_core.sv
// ----------------------------------------------------------------------------
// bbox_affine_point_register_core
// Maps target points into the reference bounding box, per axis min-max scale.
// ----------------------------------------------------------------------------
//  channel | handshake        | fields
//  --------+------------------+------------------------------------------------
//  request | push / full      | mode, x_coord, y_coord, z_coord
//  result  | pop / empty      | x_mapped, y_mapped, z_mapped, degenerate_axes
//
//  Box updates and clears take effect at the accepting edge, one per cycle while full is low.
//  With the back end idle, a transform result is ready after the digit-serial multiply,
//  the overflow check, the radix-2 divide and the final offset and clamp in each axis
//  lane; the next queued transform starts in the cycle after the result is loaded.
//  full rises while JOB_DEPTH transforms wait; a held result stalls the back, and the front once full rises.
//  Reset (rst, synchronous) empties the queues and sets both boxes empty.
// ----------------------------------------------------------------------------
module bbox_affine_point_register_core
  import bapr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int JOB_DEPTH  = JOB_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            mode,
  input  logic [COORD_BITS-1:0] x_coord,
  input  logic [COORD_BITS-1:0] y_coord,
  input  logic [COORD_BITS-1:0] z_coord,
  input  logic                  pop,
  output logic                  empty,
  output logic [COORD_BITS-1:0] x_mapped,
  output logic [COORD_BITS-1:0] y_mapped,
  output logic [COORD_BITS-1:0] z_mapped,
  output logic [2:0]            degenerate_axes
);

  localparam int JW = 3 * (4 * COORD_BITS + 2);

  logic          accept;
  logic          job_push;
  logic [JW-1:0] job_in;
  logic [JW-1:0] job_out;
  logic          job_empty;
  logic          job_pop;

  assign accept = push && !full;

  bapr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (mode),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .z_coord  (z_coord),
    .job_push (job_push),
    .job_data (job_in)
  );

  bapr_fifo #(
    .WIDTH(JW),
    .DEPTH(JOB_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  bapr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .job_empty       (job_empty),
    .job_data        (job_out),
    .job_pop         (job_pop),
    .pop             (pop),
    .empty           (empty),
    .x_mapped        (x_mapped),
    .y_mapped        (y_mapped),
    .z_mapped        (z_mapped),
    .degenerate_axes (degenerate_axes)
  );

endmodule

// File: tb/tb_bbox_affine_point_register_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bbox_affine_point_register_core
// Self-checking bench for the bounding-box point register core. Reference and
// target points grow two boxes, transform requests are scaled from the target
// box into the reference box by a local predictor, and every popped result is
// compared field by field. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module tb_bbox_affine_point_register_core;
  import bapr_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam logic [CW-1:0] COORD_MAX = {CW{1'b1}};
  localparam int RANDOM_ITEMS = 1550;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [2:0]    flags;
  } mapped_point_t;

  class bbox_map_scoreboard;
    logic [CW-1:0] tgt_lo[3];
    logic [CW-1:0] tgt_hi[3];
    logic [CW-1:0] ref_lo[3];
    logic [CW-1:0] ref_hi[3];
    mapped_point_t pending_maps[$];
    int errors;

    function new();
      errors = 0;
      clear_boxes();
    endfunction

    function void clear_boxes();
      for (int a = 0; a < 3; a++) begin
        tgt_lo[a] = COORD_MAX;
        tgt_hi[a] = '0;
        ref_lo[a] = COORD_MAX;
        ref_hi[a] = '0;
      end
    endfunction

    function logic [CW-1:0] scale_axis(int a, logic [CW-1:0] p, output bit degen);
      logic [63:0] rext, span, diff, q;
      bit below;
      if (tgt_hi[a] <= tgt_lo[a]) begin
        degen = 1'b1;
        return ref_lo[a];
      end
      degen = 1'b0;
      rext  = (ref_hi[a] >= ref_lo[a]) ? 64'(ref_hi[a]) - 64'(ref_lo[a]) : 64'd0;
      span  = 64'(tgt_hi[a]) - 64'(tgt_lo[a]);
      below = p < tgt_lo[a];
      diff  = below ? 64'(tgt_lo[a]) - 64'(p) : 64'(p) - 64'(tgt_lo[a]);
      q     = (diff * rext) / span;
      if (q > 64'(COORD_MAX)) q = 64'(COORD_MAX);
      if (below) return (q >= 64'(ref_lo[a])) ? '0 : CW'(64'(ref_lo[a]) - q);
      q = q + 64'(ref_lo[a]);
      return (q > 64'(COORD_MAX)) ? COORD_MAX : CW'(q);
    endfunction

    function void note_request(mode_t m, logic [CW-1:0] x, logic [CW-1:0] y,
                               logic [CW-1:0] z);
      logic [CW-1:0] p[3];
      mapped_point_t e;
      bit d;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      case (m)
        MODE_CLEAR: clear_boxes();
        MODE_REF: begin
          for (int a = 0; a < 3; a++) begin
            if (p[a] < ref_lo[a]) ref_lo[a] = p[a];
            if (p[a] > ref_hi[a]) ref_hi[a] = p[a];
          end
        end
        MODE_TGT: begin
          for (int a = 0; a < 3; a++) begin
            if (p[a] < tgt_lo[a]) tgt_lo[a] = p[a];
            if (p[a] > tgt_hi[a]) tgt_hi[a] = p[a];
          end
        end
        default: begin
          e.flags = '0;
          e.x = scale_axis(0, p[0], d);
          e.flags[0] = d;
          e.y = scale_axis(1, p[1], d);
          e.flags[1] = d;
          e.z = scale_axis(2, p[2], d);
          e.flags[2] = d;
          pending_maps = {pending_maps, e};
        end
      endcase
    endfunction

    function void check_result(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               logic [2:0] flags);
      mapped_point_t e;
      if (pending_maps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%h y=%h z=%h flags=%b", $time, x, y, z, flags);
        return;
      end
      e = pending_maps.pop_front();
      if (x !== e.x) begin
        errors++;
        $display("%0t: x_mapped expected %h actual %h", $time, e.x, x);
      end
      if (y !== e.y) begin
        errors++;
        $display("%0t: y_mapped expected %h actual %h", $time, e.y, y);
      end
      if (z !== e.z) begin
        errors++;
        $display("%0t: z_mapped expected %h actual %h", $time, e.z, z);
      end
      if (flags !== e.flags) begin
        errors++;
        $display("%0t: degenerate_axes expected %b actual %b", $time, e.flags, flags);
      end
    endfunction

    function int pending();
      return pending_maps.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          push;
  logic          full;
  logic [1:0]    mode;
  logic [CW-1:0] x_coord;
  logic [CW-1:0] y_coord;
  logic [CW-1:0] z_coord;
  logic          pop;
  logic          empty;
  logic [CW-1:0] x_mapped;
  logic [CW-1:0] y_mapped;
  logic [CW-1:0] z_mapped;
  logic [2:0]    degenerate_axes;

  bbox_map_scoreboard sb;
  int  cycles = 0;
  int  items_sent = 0;
  bit  push_quiet = 1'b0;
  bit  pop_quiet = 1'b0;

  bbox_affine_point_register_core uut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .mode            (mode),
    .x_coord         (x_coord),
    .y_coord         (y_coord),
    .z_coord         (z_coord),
    .pop             (pop),
    .empty           (empty),
    .x_mapped        (x_mapped),
    .y_mapped        (y_mapped),
    .z_mapped        (z_mapped),
    .degenerate_axes (degenerate_axes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** bbox_affine_point_register_core: FAILED **");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COORD_MAX;
      2:       return CW'($urandom_range(0, 255));
      3:       return COORD_MAX - CW'($urandom_range(0, 255));
      default: return CW'($urandom());
    endcase
  endfunction

  function automatic logic [CW-1:0] jitter(logic [CW-1:0] base);
    return base + CW'($urandom_range(0, 1023)) - CW'(512);
  endfunction

  // Draw the idle gap; flip into stretches with no idling now and then.
  function automatic int draw_gap(ref bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic send_request(mode_t m, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [CW-1:0] z);
    int gap;
    gap = draw_gap(push_quiet);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    mode    <= m;
    x_coord <= x;
    y_coord <= y;
    z_coord <= z;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(m, x, y, z);
    items_sent++;
  endtask

  task automatic drain_results();
    int gap;
    forever begin
      gap = draw_gap(pop_quiet);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_result(x_mapped, y_mapped, z_mapped, degenerate_axes);
    end
  endtask

  initial begin
    logic [CW-1:0] t[3];
    logic [CW-1:0] v[3];
    int n;
    int total;

    sb      = new();
    rst     = 1'b1;
    push    = 1'b0;
    pop     = 1'b0;
    mode    = MODE_REF;
    x_coord = '0;
    y_coord = '0;
    z_coord = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // Both boxes empty: every axis degenerate, result holds the reference low.
    send_request(MODE_XFORM, 24'h123456, '0, COORD_MAX);
    send_request(MODE_REF, '0, '0, '0);
    send_request(MODE_REF, COORD_MAX, COORD_MAX, 24'h000100);
    send_request(MODE_XFORM, 24'h000001, 24'h000002, 24'h000003);
    // Single target point: zero extent on all axes.
    send_request(MODE_TGT, 24'h000100, 24'h001000, 24'h010000);
    send_request(MODE_XFORM, 24'h000100, 24'h001000, 24'h010000);
    // Y keeps a zero target extent.
    send_request(MODE_TGT, 24'h000200, 24'h001000, 24'h020000);
    send_request(MODE_XFORM, 24'h000180, 24'h001000, 24'h018000);
    // Above the target box: x saturates high.
    send_request(MODE_XFORM, COORD_MAX, COORD_MAX, COORD_MAX);
    // Below the target box: saturate at zero.
    send_request(MODE_XFORM, '0, '0, '0);
    send_request(MODE_XFORM, 24'h0000C0, 24'h000FFF, 24'h00F000);
    send_request(MODE_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX);
    send_request(MODE_TGT, '0, '0, '0);
    send_request(MODE_TGT, COORD_MAX, COORD_MAX, COORD_MAX);
    // Reference box empty: zero reference extent.
    send_request(MODE_XFORM, 24'h800000, '0, COORD_MAX);
    send_request(MODE_REF, 24'h000100, 24'h000200, 24'h000300);
    send_request(MODE_REF, 24'h000200, 24'h000200, 24'h000400);
    send_request(MODE_XFORM, 24'h7FFFFF, 24'h800000, COORD_MAX);
    send_request(MODE_XFORM, '0, '0, '0);
    send_request(MODE_CLEAR, '0, '0, '0);
    send_request(MODE_REF, 24'hAAAAAA, 24'h555555, 24'hA5A5A5);
    send_request(MODE_REF, 24'h555555, 24'hAAAAAA, 24'h5A5A5A);
    send_request(MODE_TGT, 24'h0F0F0F, 24'hF0F0F0, 24'h00FF00);
    send_request(MODE_TGT, 24'hF0F0F0, 24'h0F0F0F, 24'hFF00FF);
    send_request(MODE_XFORM, 24'h3C3C3C, 24'hC3C3C3, 24'h5A5A5A);

    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 9) < 7)
          send_request(MODE_CLEAR, rand_coord(), rand_coord(), rand_coord());
        n = $urandom_range(1, 4);
        repeat (n) send_request(MODE_REF, rand_coord(), rand_coord(), rand_coord());
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          // Repeat an axis of the first target point to make zero extents likelier.
          for (int a = 0; a < 3; a++)
            v[a] = (i > 0 && $urandom_range(0, 5) == 0) ? t[a] : rand_coord();
          if (i == 0) t = v;
          send_request(MODE_TGT, v[0], v[1], v[2]);
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
          for (int a = 0; a < 3; a++)
            v[a] = $urandom_range(0, 1) ? rand_coord() : jitter(t[a]);
          send_request(MODE_XFORM, v[0], v[1], v[2]);
        end
      end else begin
        n = $urandom_range(1, 5);
        repeat (n)
          send_request(mode_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                       rand_coord());
      end
    end
    push <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** bbox_affine_point_register_core: PASSED **");
    end else begin
      $display("** bbox_affine_point_register_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: bbox_affine_point_register_core.f
sv/bapr_pkg.sv
sv/bapr_fifo.sv
sv/bapr_front.sv
sv/bapr_lane.sv
sv/bapr_back.sv
sv/bbox_affine_point_register_core.sv
tb/tb_bbox_affine_point_register_core.sv
